>>> rtl/core/ppsq_pkg.sv
// Package for the parallel parking sequencer: command constants, register
// indexes, reset values and the structs passed between the core modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppsq_pkg;

    localparam int DIST_W = 11;
    localparam int ODO_W  = 24;
    localparam int STEP_W = 8;
    localparam int GAP_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // speed commands
    localparam logic signed [2:0] SPEED_CRUISE  = 3'sd3;
    localparam logic signed [2:0] SPEED_CREEP   = 3'sd1;
    localparam logic signed [2:0] SPEED_STOP    = 3'sd0;
    localparam logic signed [2:0] SPEED_REVERSE = -3'sd1;

    // steering in milliradians
    localparam logic signed [11:0] STEER_STRAIGHT     = 12'sd0;
    localparam logic signed [11:0] STEER_RIGHT_LOCK   = 12'sd785;
    localparam logic signed [11:0] STEER_LEFT_LOCK    = -12'sd436;
    localparam logic signed [11:0] STEER_SLIGHT_RIGHT = 12'sd175;

    // register reset values
    localparam logic [GAP_W-1:0]  RST_MIN_GAP        = 16'd40;
    localparam logic [STEP_W-1:0] RST_CREEP_END      = 8'd10;
    localparam logic [STEP_W-1:0] RST_PAUSE_END      = 8'd15;
    localparam logic [STEP_W-1:0] RST_REV_RIGHT_END  = 8'd70;
    localparam logic [STEP_W-1:0] RST_REV_LEFT_END   = 8'd95;
    localparam logic [STEP_W-1:0] RST_HOLD_LEFT_END  = 8'd105;
    localparam logic [STEP_W-1:0] RST_STRAIGHTEN_END = 8'd130;

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_GAP        = 3'd0,
        CFG_CREEP_END      = 3'd1,
        CFG_PAUSE_END      = 3'd2,
        CFG_REV_RIGHT_END  = 3'd3,
        CFG_REV_LEFT_END   = 3'd4,
        CFG_HOLD_LEFT_END  = 3'd5,
        CFG_STRAIGHTEN_END = 3'd6
    } t_cfg_idx;

    // gap tracker phases
    typedef enum logic [2:0] {
        MP_ARM  = 3'b001,
        MP_SEEK = 3'b010,
        MP_GAP  = 3'b100
    } t_meas_phase;

    typedef struct packed {
        logic [STEP_W-1:0] creep_end;
        logic [STEP_W-1:0] pause_end;
        logic [STEP_W-1:0] rev_right_end;
        logic [STEP_W-1:0] rev_left_end;
        logic [STEP_W-1:0] hold_left_end;
        logic [STEP_W-1:0] straighten_end;
    } t_phase_cfg;

    typedef struct packed {
        logic signed [2:0]  speed;
        logic signed [11:0] steer;
        logic               advance;
    } t_phase_cmd;

    typedef struct packed {
        logic             ended;
        logic [ODO_W-1:0] len;
    } t_gap_result;

endpackage

`default_nettype wire

>>> rtl/core/ppsq_in_if.sv
// Input channel of the parking sequencer: valid/ready plus one sensor tick.
// Depends on ppsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppsq_in_if
    import ppsq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] side_distance;
    logic [ODO_W-1:0]         odometer;

    modport source (output valid, output side_distance, output odometer, input ready);
    modport sink   (input valid, input side_distance, input odometer, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ppsq_out_if.sv
// Output channel of the parking sequencer: valid/ready plus one command result.
// Depends on ppsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppsq_out_if
    import ppsq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic signed [2:0]   speed_cmd;
    logic signed [11:0]  steer_mrad;
    logic [STEP_W-1:0]   sequence_step;
    logic                gap_ended;
    logic [ODO_W-1:0]    gap_length;

    modport source (output valid, output speed_cmd, output steer_mrad,
                    output sequence_step, output gap_ended, output gap_length,
                    input ready);
    modport sink   (input valid, input speed_cmd, input steer_mrad,
                    input sequence_step, input gap_ended, input gap_length,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/parallel_parking_sequencer_top.sv
// Parallel parking sequencer top level.
// Latency: a result is valid in the cycle after its tick is accepted.
// Throughput: one tick per cycle; ready drops only while a result waits
// in the output register and the sink is not ready.
// Reset (i_rst_n, synchronous, active low): step 0, gap tracker arming,
// registers back to their defaults, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module parallel_parking_sequencer_top
    import ppsq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    ppsq_in_if.sink               i_in,
    ppsq_out_if.source            o_out
);

    logic [GAP_W-1:0]  r_min_gap;
    t_phase_cfg        r_cfg;
    logic [STEP_W-1:0] r_step, n_step;

    logic               r_out_valid;
    logic signed [2:0]  r_speed;
    logic signed [11:0] r_steer;
    logic [STEP_W-1:0]  r_seq_step;
    logic               r_gap_ended;
    logic [ODO_W-1:0]   r_gap_length;

    logic        in_ready, accept, start_park;
    t_phase_cmd  cmd;
    t_gap_result gap;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap            <= RST_MIN_GAP;
            r_cfg.creep_end      <= RST_CREEP_END;
            r_cfg.pause_end      <= RST_PAUSE_END;
            r_cfg.rev_right_end  <= RST_REV_RIGHT_END;
            r_cfg.rev_left_end   <= RST_REV_LEFT_END;
            r_cfg.hold_left_end  <= RST_HOLD_LEFT_END;
            r_cfg.straighten_end <= RST_STRAIGHTEN_END;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_GAP:        r_min_gap            <= i_cfg_data;
                CFG_CREEP_END:      r_cfg.creep_end      <= i_cfg_data[STEP_W-1:0];
                CFG_PAUSE_END:      r_cfg.pause_end      <= i_cfg_data[STEP_W-1:0];
                CFG_REV_RIGHT_END:  r_cfg.rev_right_end  <= i_cfg_data[STEP_W-1:0];
                CFG_REV_LEFT_END:   r_cfg.rev_left_end   <= i_cfg_data[STEP_W-1:0];
                CFG_HOLD_LEFT_END:  r_cfg.hold_left_end  <= i_cfg_data[STEP_W-1:0];
                CFG_STRAIGHTEN_END: r_cfg.straighten_end <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    ppsq_phase_decode u_decode (
        .i_step (r_step),
        .i_cfg  (r_cfg),
        .o_cmd  (cmd)
    );

    ppsq_gap_tracker u_gap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_dist   (i_in.side_distance),
        .i_odo    (i_in.odometer),
        .o_res    (gap)
    );

    // a step never advances to zero, so "cruising" is simply step == 0
    assign start_park = gap.ended && (r_step == '0)
                        && (gap.len > {{(ODO_W-GAP_W){1'b0}}, r_min_gap});

    always_comb begin
        n_step = r_step;
        if (cmd.advance) begin
            n_step = r_step + {{(STEP_W-1){1'b0}}, 1'b1};
        end
        if (start_park) begin
            n_step = {{(STEP_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (accept) begin
            r_step <= n_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_speed      <= cmd.speed;
            r_steer      <= cmd.steer;
            r_seq_step   <= r_step;
            r_gap_ended  <= gap.ended;
            r_gap_length <= gap.len;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.speed_cmd     = r_speed;
    assign o_out.steer_mrad    = r_steer;
    assign o_out.sequence_step = r_seq_step;
    assign o_out.gap_ended     = r_gap_ended;
    assign o_out.gap_length    = r_gap_length;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_step_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_step != '0) |=> (r_step != '0))
        else $error("manoeuvre step returned to zero");

    a_len_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_gap_ended) |-> (r_gap_length == '0))
        else $error("gap length reported without a closed gap");

    a_cruise_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seq_step == '0) |->
            (r_speed == SPEED_CRUISE && r_steer == STEER_STRAIGHT))
        else $error("step zero did not command cruise");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ppsq_gap_tracker.sv
// Gap tracker: watches the side distance for a fall and a later rise and
// measures the odometer span between them. Depends on ppsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppsq_gap_tracker
    import ppsq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic signed [DIST_W-1:0] i_dist,
    input  wire logic [ODO_W-1:0]         i_odo,
    output t_gap_result                   o_res
);

    t_meas_phase              r_phase, n_phase;
    logic signed [DIST_W-1:0] r_prev;
    logic [ODO_W-1:0]         r_gap_start, n_gap_start;

    logic prev_pos, dist_pos;

    assign prev_pos = (r_prev > $signed({DIST_W{1'b0}}));
    assign dist_pos = (i_dist > $signed({DIST_W{1'b0}}));

    always_comb begin
        n_phase     = r_phase;
        n_gap_start = r_gap_start;
        o_res.ended = 1'b0;
        o_res.len   = '0;
        unique case (r_phase)
            MP_SEEK: begin
                if (prev_pos && !dist_pos) begin
                    n_phase     = MP_GAP;
                    n_gap_start = i_odo;
                end
            end
            MP_GAP: begin
                if (!prev_pos && dist_pos) begin
                    n_phase     = MP_SEEK;
                    o_res.ended = 1'b1;
                    o_res.len   = i_odo - r_gap_start;  // wraps mod 2^24
                end
            end
            default: begin
                n_phase = MP_SEEK;  // arming tick, also any stray code
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= MP_ARM;
            r_prev      <= '0;
            r_gap_start <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_prev      <= i_dist;
            r_gap_start <= n_gap_start;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ppsq_phase_decode.sv
// Phase decoder: maps the manoeuvre step onto speed and steering commands
// using the configured phase bounds. Depends on ppsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppsq_phase_decode
    import ppsq_pkg::*;
(
    input  wire logic [STEP_W-1:0] i_step,
    input  wire t_phase_cfg        i_cfg,
    output t_phase_cmd             o_cmd
);

    function automatic logic in_rng(input logic [STEP_W-1:0] s,
                                    input logic [STEP_W-1:0] lo,
                                    input logic [STEP_W-1:0] hi);
        return (s >= lo) && (s < hi);
    endfunction

    always_comb begin
        o_cmd.speed   = SPEED_STOP;
        o_cmd.steer   = STEER_STRAIGHT;
        o_cmd.advance = 1'b1;
        // first matching range wins; empty ranges never match
        if (i_step == '0) begin
            o_cmd.speed   = SPEED_CRUISE;
            o_cmd.advance = 1'b0;
        end else if (i_step < i_cfg.creep_end) begin
            o_cmd.speed = SPEED_CREEP;
        end else if (in_rng(i_step, i_cfg.creep_end, i_cfg.pause_end)) begin
            o_cmd.speed = SPEED_STOP;
        end else if (in_rng(i_step, i_cfg.pause_end, i_cfg.rev_right_end)) begin
            o_cmd.speed = SPEED_REVERSE;
            o_cmd.steer = STEER_RIGHT_LOCK;
        end else if (in_rng(i_step, i_cfg.rev_right_end, i_cfg.rev_left_end)) begin
            o_cmd.speed = SPEED_REVERSE;
            o_cmd.steer = STEER_LEFT_LOCK;
        end else if (in_rng(i_step, i_cfg.rev_left_end, i_cfg.hold_left_end)) begin
            o_cmd.speed = SPEED_STOP;
            o_cmd.steer = STEER_LEFT_LOCK;
        end else if (in_rng(i_step, i_cfg.hold_left_end, i_cfg.straighten_end)) begin
            o_cmd.speed = SPEED_CREEP;
            o_cmd.steer = STEER_SLIGHT_RIGHT;
        end else begin
            o_cmd.advance = 1'b0;  // outside every phase: stop, hold step
        end
    end

endmodule

`default_nettype wire

>>> sim/parallel_parking_sequencer_top_test.sv
// Self-checking testbench for parallel_parking_sequencer_top: tick stimulus, random
// handshake gaps, register rewrites between phases, command prediction per tick.
// Depends on ppsq_pkg, ppsq_in_if, ppsq_out_if and the RTL top level.
`timescale 1ns / 1ps

module parallel_parking_sequencer_top_test;
    import ppsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_TICKS    = 116;
    localparam logic [IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic signed [DIST_W-1:0] side;
        logic [ODO_W-1:0]         odo;
    } t_tick;

    typedef struct packed {
        logic signed [2:0]  speed;
        logic signed [11:0] steer;
        logic [STEP_W-1:0]  step;
        logic               ended;
        logic [ODO_W-1:0]   len;
    } t_cmd_tick;

    typedef enum logic [1:0] {
        TRK_ARM  = 2'd0,
        TRK_SEEK = 2'd1,
        TRK_GAP  = 2'd2
    } t_trk;

    typedef enum {
        TUNE_KEEP,
        TUNE_FLOOR,
        TUNE_CEIL,
        TUNE_SCRAMBLE,
        TUNE_CLIMB
    } t_tune;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    ppsq_in_if  tick_if ();
    ppsq_out_if cmd_if ();

    parallel_parking_sequencer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if),
        .o_out      (cmd_if)
    );

    always #2 i_clk = ~i_clk;

    // predictor state and register copies
    logic [STEP_W-1:0]        man_step  = '0;
    t_trk                     trk       = TRK_ARM;
    logic signed [DIST_W-1:0] last_side = '0;
    logic [ODO_W-1:0]         gap_from  = '0;
    logic [GAP_W-1:0]         min_gap   = RST_MIN_GAP;
    // [0] is the fixed lower bound of the creep phase, [1..6] follow the register indexes
    logic [STEP_W-1:0]        step_bound [0:6];

    t_tick     tick_queue [$];
    t_cmd_tick cmd_expect [$];
    logic [ODO_W-1:0] odo_now = '0;

    int    bad_results  = 0;
    int    results_seen = 0;
    int    hold_left    = 0;
    logic  hold_done    = 1'b0;
    int    quiet        = 0;
    int    src_pause    = 0;
    int    snk_pause    = 0;
    logic  src_calm     = 1'b0;
    logic  snk_calm     = 1'b0;
    t_tune tune_plan [8] = '{TUNE_KEEP, TUNE_FLOOR, TUNE_CLIMB, TUNE_SCRAMBLE,
                             TUNE_CLIMB, TUNE_CEIL, TUNE_SCRAMBLE, TUNE_CLIMB};

    function automatic t_cmd_tick plan_tick(input logic signed [DIST_W-1:0] side,
                                            input logic [ODO_W-1:0] odo);
        t_cmd_tick r;
        logic      hit;
        r.speed = SPEED_STOP;
        r.steer = STEER_STRAIGHT;
        r.step  = man_step;
        r.ended = 1'b0;
        r.len   = '0;
        hit     = 1'b0;
        if (man_step == '0) begin
            r.speed = SPEED_CRUISE;
        end else begin
            // first matching range wins; empty ranges never match
            for (int k = CFG_CREEP_END; k <= CFG_STRAIGHTEN_END; k++) begin
                if (!hit && man_step >= step_bound[k-1] && man_step < step_bound[k]) begin
                    hit = 1'b1;
                    case (k)
                        CFG_CREEP_END: r.speed = SPEED_CREEP;
                        CFG_PAUSE_END: r.speed = SPEED_STOP;
                        CFG_REV_RIGHT_END: begin
                            r.speed = SPEED_REVERSE;
                            r.steer = STEER_RIGHT_LOCK;
                        end
                        CFG_REV_LEFT_END: begin
                            r.speed = SPEED_REVERSE;
                            r.steer = STEER_LEFT_LOCK;
                        end
                        CFG_HOLD_LEFT_END: begin
                            r.speed = SPEED_STOP;
                            r.steer = STEER_LEFT_LOCK;
                        end
                        default: begin
                            r.speed = SPEED_CREEP;
                            r.steer = STEER_SLIGHT_RIGHT;
                        end
                    endcase
                end
            end
            // outside every range the car stands and the step holds
            if (hit) man_step = man_step + 1'b1;
        end
        case (trk)
            TRK_SEEK: begin
                if (last_side > 0 && side <= 0) begin
                    trk      = TRK_GAP;
                    gap_from = odo;
                end
            end
            TRK_GAP: begin
                if (last_side <= 0 && side > 0) begin
                    trk     = TRK_SEEK;
                    r.ended = 1'b1;
                    r.len   = odo - gap_from;
                    if (man_step == '0 && r.len > min_gap) man_step = 8'd1;
                end
            end
            default: trk = TRK_SEEK;
        endcase
        last_side = side;
        return r;
    endfunction

    function automatic void add_at(input int side, input int odo);
        t_tick t;
        odo_now = odo[ODO_W-1:0];
        t.side  = side[DIST_W-1:0];
        t.odo   = odo_now;
        tick_queue.push_back(t);
    endfunction

    function automatic void add_tick(input int side, input int adv);
        add_at(side, int'(odo_now) + adv);
    endfunction

    // mostly clean object/gap/object patterns, some noise and odometer jumps
    task automatic add_traffic(input int n);
        int target;
        target = tick_queue.size() + n;
        while (tick_queue.size() < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    repeat ($urandom_range(1, 5))
                        add_tick(int'($urandom_range(0, 1024)) - 1, $urandom_range(0, 25));
                end
                8: odo_now = ODO_W'(24'hFFFFFF - $urandom_range(0, 60));
                9: odo_now = ODO_W'($urandom);
                default: begin
                    repeat ($urandom_range(1, 4))
                        add_tick($urandom_range(1, 1023), $urandom_range(0, 25));
                    repeat ($urandom_range(1, 6))
                        add_tick($urandom_range(0, 1) ? -1 : 0, $urandom_range(0, 25));
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_GAP: min_gap = val;
            CFG_CREEP_END, CFG_PAUSE_END, CFG_REV_RIGHT_END, CFG_REV_LEFT_END,
            CFG_HOLD_LEFT_END, CFG_STRAIGHTEN_END: step_bound[idx] = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || tick_if.valid || cmd_expect.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic retune(input t_tune mode);
        int         lim;
        logic [7:0] pad;
        lim = int'(man_step) + $urandom_range(0, 8);
        for (int k = CFG_CREEP_END; k <= CFG_STRAIGHTEN_END; k++) begin
            case (mode)
                TUNE_FLOOR:    lim = 1;
                TUNE_CEIL:     lim = 255;
                TUNE_SCRAMBLE: lim = $urandom_range(1, 255);
                default:       lim = lim + $urandom_range(0, 15);
            endcase
            if (lim > 255) lim = 255;
            if (lim < 1) lim = 1;
            pad = 8'($urandom);
            write_reg(k[IDX_W-1:0], {pad, lim[7:0]});
        end
        case (mode)
            TUNE_FLOOR: write_reg(CFG_MIN_GAP, 16'd0);
            TUNE_CEIL:  write_reg(CFG_MIN_GAP, 16'hFFFF);
            default:    write_reg(CFG_MIN_GAP, CFG_W'($urandom));
        endcase
    endtask

    always @(posedge i_clk) begin : drive_ticks
        t_tick nxt;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            src_pause     <= 0;
        end else begin
            if (tick_if.valid && tick_if.ready)
                cmd_expect.push_back(plan_tick(tick_if.side_distance, tick_if.odometer));
            if (!tick_if.valid || tick_if.ready) begin
                if (src_pause != 0) begin
                    src_pause     <= src_pause - 1;
                    tick_if.valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    nxt = tick_queue.pop_front();
                    tick_if.valid         <= 1'b1;
                    tick_if.side_distance <= nxt.side;
                    tick_if.odometer      <= nxt.odo;
                    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
                    src_pause <= src_calm ? 0 : $urandom_range(0, 10);
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_cmds
        t_cmd_tick want;
        t_cmd_tick got;
        logic      rdy_next;
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
            snk_pause    <= 0;
        end else begin
            rdy_next = cmd_if.ready;
            if (cmd_if.valid && cmd_if.ready) begin
                got.speed = cmd_if.speed_cmd;
                got.steer = cmd_if.steer_mrad;
                got.step  = cmd_if.sequence_step;
                got.ended = cmd_if.gap_ended;
                got.len   = cmd_if.gap_length;
                results_seen <= results_seen + 1;
                if (cmd_expect.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected command transaction: step %0d", got.step);
                end else begin
                    want = cmd_expect.pop_front();
                    if (got.speed !== want.speed || got.steer !== want.steer ||
                        got.step !== want.step || got.ended !== want.ended ||
                        got.len !== want.len) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("cmd mismatch: exp speed %0d steer %0d step %0d gap %0b/%0d",
                                     want.speed, want.steer, want.step, want.ended, want.len,
                                     " act speed %0d steer %0d step %0d gap %0b/%0d",
                                     got.speed, got.steer, got.step, got.ended, got.len);
                    end
                end
                if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
                if (!snk_calm) begin
                    snk_pause <= $urandom_range(0, 10);
                    rdy_next = 1'b0;
                end
            end else if (!cmd_if.ready) begin
                if (snk_pause != 0) snk_pause <= snk_pause - 1;
                else rdy_next = 1'b1;
            end
            if (hold_left != 0) rdy_next = 1'b0;
            cmd_if.ready <= rdy_next;
        end
    end

    // one long sink stall so the output register fills and input ready drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        tick_if.valid         = 1'b0;
        tick_if.side_distance = '0;
        tick_if.odometer      = '0;
        cmd_if.ready          = 1'b0;
        step_bound[0]                  = 8'd1;
        step_bound[CFG_CREEP_END]      = RST_CREEP_END;
        step_bound[CFG_PAUSE_END]      = RST_PAUSE_END;
        step_bound[CFG_REV_RIGHT_END]  = RST_REV_RIGHT_END;
        step_bound[CFG_REV_LEFT_END]   = RST_REV_LEFT_END;
        step_bound[CFG_HOLD_LEFT_END]  = RST_HOLD_LEFT_END;
        step_bound[CFG_STRAIGHTEN_END] = RST_STRAIGHTEN_END;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_SPARE_IDX, 16'hFFFF);

        // default registers: arming tick, zero gap, gap equal to threshold, wrap
        @(negedge i_clk);
        add_at(500, 1000);
        add_at(1023, 1000);
        add_at(0, 1000);
        add_at(5, 1000);
        add_at(-1, 1010);
        add_at(-1, 1030);
        add_at(1, 1050);
        add_at(0, 24'hFFFFFF);
        add_at(700, 24'h00001F);
        settle();

        write_reg(CFG_MIN_GAP, 16'd0);
        @(negedge i_clk);
        add_at(-1, 32);
        add_at(3, 32);
        settle();

        // widest threshold: equal length stays cruising, one more starts parking
        write_reg(CFG_MIN_GAP, 16'hFFFF);
        @(negedge i_clk);
        add_at(0, 100);
        add_at(9, 100 + 65535);
        add_at(-1, 200000);
        add_at(1, 200000 + 65536);
        add_at(0, 5000);
        add_at(512, 4000);
        add_at(-1, 4001);
        add_at(1023, 4002);

        for (int r = 0; r < 8; r++) begin
            if (tune_plan[r] != TUNE_KEEP) begin
                settle();
                retune(tune_plan[r]);
            end
            @(negedge i_clk);
            add_traffic(PHASE_TICKS);
        end
        settle();
        repeat (10) @(posedge i_clk);
        if (bad_results == 0 && cmd_expect.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
